// ===== src/wfd_pkg.sv =====
`default_nettype none
package wfd_pkg;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam logic [2:0] KIND_TEXT         = 3'd0;
  localparam logic [2:0] KIND_TEXT_PART    = 3'd1;
  localparam logic [2:0] KIND_BINARY       = 3'd2;
  localparam logic [2:0] KIND_BINARY_PART  = 3'd3;
  localparam logic [2:0] KIND_PING         = 3'd4;
  localparam logic [2:0] KIND_PONG         = 3'd5;
  localparam logic [2:0] KIND_ERROR        = 3'd6;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN7_MAX   = 7'd125;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [2:0] EXT16_LEFT = 3'd1;
  localparam logic [2:0] EXT64_LEFT = 3'd7;
  localparam logic [2:0] KEY_LEFT   = 3'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [2:0] frame_kind;
    logic       last;
  } result_t;

  function automatic logic [2:0] kind_of(input logic [7:0] hdr);
    logic [2:0] k;
    case (hdr[3:0])
      OP_CONT, OP_TEXT: k = hdr[7] ? KIND_TEXT : KIND_TEXT_PART;
      OP_BINARY:        k = hdr[7] ? KIND_BINARY : KIND_BINARY_PART;
      OP_PING:          k = KIND_PING;
      OP_PONG:          k = KIND_PONG;
      default:          k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== src/wfd_if.sv =====
`default_nettype none
interface wfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface wfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic [2:0] frame_kind;
  logic       last;

  modport source (output valid, output payload_byte, output has_byte,
                  output frame_kind, output last, input ready);
  modport sink (input valid, input payload_byte, input has_byte,
                input frame_kind, input last, output ready);
endinterface
`default_nettype wire

// ===== src/wfd_in_stage.sv =====
`default_nettype none
module wfd_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_data_byte,
  output logic                    in_ready,
  input  wire logic               take,
  output wfd_pkg::byte_item_t     item
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data_byte;
    end
  end

  assign item.valid     = valid_r;
  assign item.data_byte = data_r;

endmodule
`default_nettype wire

// ===== src/wfd_parser.sv =====
`default_nettype none
module wfd_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wfd_pkg::byte_item_t item,
  output logic                     take,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output wfd_pkg::result_t         result
);

  logic [2:0]        phase_r, phase_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic              mask_on_r, mask_on_nxt;
  logic [2:0]        left_r, left_nxt;
  logic [63:0]       rem_r, rem_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic              out_valid_r;
  wfd_pkg::result_t  res_r;
  wfd_pkg::result_t  res_nxt;
  logic              emit;
  logic              out_free;
  logic [7:0]        b;
  logic [63:0]       rem_sh;
  logic [7:0]        key_byte;
  logic              pay_last;

  assign out_free = !out_valid_r || out_ready;
  assign take     = item.valid && out_free;
  assign b        = item.data_byte;
  assign rem_sh   = {rem_r[55:0], b};
  assign pay_last = (rem_r[63:1] == 63'd0);

  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    mask_on_nxt = mask_on_r;
    left_nxt    = left_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    emit        = 1'b0;
    res_nxt     = '{payload_byte: 8'd0, has_byte: 1'b0, frame_kind: kind_r, last: 1'b1};
    case (phase_r)
      wfd_pkg::PH_HDR0: begin
        kind_nxt  = wfd_pkg::kind_of(b);
        phase_nxt = wfd_pkg::PH_HDR1;
      end
      wfd_pkg::PH_HDR1: begin
        mask_on_nxt = b[7];
        key_nxt     = 32'd0;
        rem_nxt     = 64'd0;
        if (b[6:0] <= wfd_pkg::LEN7_MAX) begin
          rem_nxt = {57'd0, b[6:0]};
          if (b[7]) begin
            left_nxt  = wfd_pkg::KEY_LEFT;
            phase_nxt = wfd_pkg::PH_MASK;
          end else begin
            pos_nxt = 2'd0;
            if (b[6:0] == 7'd0) begin
              phase_nxt = wfd_pkg::PH_HDR0;
              emit      = 1'b1;
            end else begin
              phase_nxt = wfd_pkg::PH_PAYLOAD;
            end
          end
        end else begin
          left_nxt  = (b[6:0] == wfd_pkg::LEN7_EXT16) ? wfd_pkg::EXT16_LEFT
                                                      : wfd_pkg::EXT64_LEFT;
          phase_nxt = wfd_pkg::PH_EXTLEN;
        end
      end
      wfd_pkg::PH_EXTLEN: begin
        rem_nxt = rem_sh;
        if (left_r != 3'd0) begin
          left_nxt = left_r - 3'd1;
        end else if (mask_on_r) begin
          left_nxt  = wfd_pkg::KEY_LEFT;
          phase_nxt = wfd_pkg::PH_MASK;
        end else begin
          pos_nxt = 2'd0;
          if (rem_sh == 64'd0) begin
            phase_nxt = wfd_pkg::PH_HDR0;
            emit      = 1'b1;
          end else begin
            phase_nxt = wfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wfd_pkg::PH_MASK: begin
        key_nxt = {key_r[23:0], b};
        if (left_r != 3'd0) begin
          left_nxt = left_r - 3'd1;
        end else begin
          pos_nxt = 2'd0;
          if (rem_r == 64'd0) begin
            phase_nxt = wfd_pkg::PH_HDR0;
            emit      = 1'b1;
          end else begin
            phase_nxt = wfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wfd_pkg::PH_PAYLOAD: begin
        pos_nxt = pos_r + 2'd1;
        if (rem_r != 64'd0) begin
          rem_nxt = rem_r - 64'd1;
        end
        if (pay_last) begin
          phase_nxt = wfd_pkg::PH_HDR0;
        end
        emit                 = 1'b1;
        res_nxt.payload_byte = mask_on_r ? (b ^ key_byte) : b;
        res_nxt.has_byte     = 1'b1;
        res_nxt.last         = pay_last;
      end
      default: begin
        phase_nxt = wfd_pkg::PH_HDR0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= wfd_pkg::PH_HDR0;
      kind_r      <= 3'd0;
      mask_on_r   <= 1'b0;
      left_r      <= 3'd0;
      rem_r       <= 64'd0;
      key_r       <= 32'd0;
      pos_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r   <= phase_nxt;
        kind_r    <= kind_nxt;
        mask_on_r <= mask_on_nxt;
        left_r    <= left_nxt;
        rem_r     <= rem_nxt;
        key_r     <= key_nxt;
        pos_r     <= pos_nxt;
      end
      if (out_free) begin
        out_valid_r <= take && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule
`default_nettype wire

// ===== src/websocket_frame_deframer.sv =====
// WebSocket frame deframer (receive side).
// in_ch: one byte of a stream of back-to-back frames per transfer
//   (valid/ready; a transfer happens when both are high at a clock edge).
// out_ch: zero or one result per input byte: unmasked payload_byte,
//   has_byte (0 only on the marker of an empty frame), frame_kind and last.
// Header bytes (first byte, length byte, extended length, mask key) give
//   no result, except that the final header byte of an empty frame gives
//   the empty-frame marker.
// Throughput: one byte per cycle while out_ch.ready is high; the parser state advances
//   once per byte, including the 64-bit length counter update.
// Path: the byte is captured in the input register, then the parser writes its
//   result to the result register, which drives out_ch.valid.
// Reset (rst_n low, synchronous): both stages empty, parser waits for the
//   first header byte of a frame.
// Stall: while out_ch.ready is low and a result is held, the parser stops;
//   the input register takes at most one more byte, then in_ch.ready drops.
`default_nettype none
module websocket_frame_deframer (
  input  wire logic clk,
  input  wire logic rst_n,
  wfd_in_if.sink    in_ch,
  wfd_out_if.source out_ch
);

  wfd_pkg::byte_item_t item;
  wfd_pkg::result_t    result;
  logic                take;
  logic                in_ready;
  logic                out_valid;

  wfd_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_data_byte (in_ch.data_byte),
    .in_ready     (in_ready),
    .take         (take),
    .item         (item)
  );

  wfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .take      (take),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .result    (result)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.payload_byte = result.payload_byte;
  assign out_ch.has_byte     = result.has_byte;
  assign out_ch.frame_kind   = result.frame_kind;
  assign out_ch.last         = result.last;

endmodule
`default_nettype wire

// ===== tb/sv/websocket_frame_deframer_tb.sv =====
module websocket_frame_deframer_tb;

  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam int unsigned LEN_SHORT = 0;
  localparam int unsigned LEN_EXT16 = 1;
  localparam int unsigned LEN_EXT64 = 2;
  localparam int unsigned RANDOM_BYTES = 1000;

  logic clk = 1'b0;
  logic rst_n;

  wfd_in_if  in_ch();
  wfd_out_if out_ch();

  websocket_frame_deframer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  logic [7:0]        byte_stream [$];
  wfd_pkg::result_t  deframed_q [$];
  int unsigned in_gap;
  int unsigned out_stall;
  bit          in_steady;
  bit          out_steady;
  int unsigned bytes_total;
  int unsigned bytes_accepted;
  int unsigned frames_queued;
  int unsigned results_seen;
  int unsigned errors;
  int unsigned kind_hits [0:7];

  // receive-side frame parser state
  logic [2:0]  rx_phase;
  logic [2:0]  rx_kind;
  logic        rx_masked;
  logic [2:0]  rx_field_left;
  logic [63:0] rx_remaining;
  logic [31:0] rx_key;
  logic [1:0]  rx_key_pos;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("tb mismatch @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic stream_add(input logic [7:0] b);
    byte_stream.insert(byte_stream.size(), b);
  endtask

  task automatic expect_add(input wfd_pkg::result_t r);
    deframed_q.insert(deframed_q.size(), r);
  endtask

  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    wfd_pkg::result_t r;
    bit               hdr_end;
    r = '0;
    hdr_end = 1'b0;
    case (rx_phase)
      wfd_pkg::PH_HDR0: begin
        case (b[3:0])
          wfd_pkg::OP_CONT, wfd_pkg::OP_TEXT:
            rx_kind = b[7] ? wfd_pkg::KIND_TEXT : wfd_pkg::KIND_TEXT_PART;
          wfd_pkg::OP_BINARY:
            rx_kind = b[7] ? wfd_pkg::KIND_BINARY : wfd_pkg::KIND_BINARY_PART;
          wfd_pkg::OP_PING: rx_kind = wfd_pkg::KIND_PING;
          wfd_pkg::OP_PONG: rx_kind = wfd_pkg::KIND_PONG;
          default:          rx_kind = wfd_pkg::KIND_ERROR;
        endcase
        rx_phase = wfd_pkg::PH_HDR1;
      end
      wfd_pkg::PH_HDR1: begin
        rx_masked = b[7];
        rx_key = '0;
        rx_remaining = '0;
        if (b[6:0] <= wfd_pkg::LEN7_MAX) begin
          rx_remaining = {57'd0, b[6:0]};
          if (rx_masked) begin
            rx_field_left = wfd_pkg::KEY_LEFT;
            rx_phase = wfd_pkg::PH_MASK;
          end else begin
            hdr_end = 1'b1;
          end
        end else begin
          rx_field_left = (b[6:0] == wfd_pkg::LEN7_EXT16) ? wfd_pkg::EXT16_LEFT
                                                          : wfd_pkg::EXT64_LEFT;
          rx_phase = wfd_pkg::PH_EXTLEN;
        end
      end
      wfd_pkg::PH_EXTLEN: begin
        rx_remaining = {rx_remaining[55:0], b};
        if (rx_field_left != 0) begin
          rx_field_left = rx_field_left - 3'd1;
        end else if (rx_masked) begin
          rx_field_left = wfd_pkg::KEY_LEFT;
          rx_phase = wfd_pkg::PH_MASK;
        end else begin
          hdr_end = 1'b1;
        end
      end
      wfd_pkg::PH_MASK: begin
        rx_key = {rx_key[23:0], b};
        if (rx_field_left != 0) rx_field_left = rx_field_left - 3'd1;
        else hdr_end = 1'b1;
      end
      wfd_pkg::PH_PAYLOAD: begin
        r.payload_byte = rx_masked ? (b ^ rx_key[31 - 8*rx_key_pos -: 8]) : b;
        rx_key_pos = rx_key_pos + 2'd1;
        if (rx_remaining != 0) rx_remaining = rx_remaining - 64'd1;
        r.has_byte = 1'b1;
        r.frame_kind = rx_kind;
        r.last = (rx_remaining == 0);
        if (r.last) rx_phase = wfd_pkg::PH_HDR0;
        expect_add(r);
      end
      default: rx_phase = wfd_pkg::PH_HDR0;
    endcase
    if (hdr_end) begin
      rx_key_pos = '0;
      if (rx_remaining == 0) begin
        rx_phase = wfd_pkg::PH_HDR0;
        r.frame_kind = rx_kind;
        r.last = 1'b1;
        expect_add(r);
      end else begin
        rx_phase = wfd_pkg::PH_PAYLOAD;
      end
    end
  endtask

  // n_pay may be short of len: the stream then ends inside the payload
  task automatic add_frame(input logic [7:0] hdr, input bit masked, input int unsigned form,
                           input logic [63:0] len, input logic [31:0] key,
                           input int unsigned n_pay);
    stream_add(hdr);
    case (form)
      LEN_SHORT: stream_add({masked, len[6:0]});
      LEN_EXT16: begin
        stream_add({masked, wfd_pkg::LEN7_EXT16});
        stream_add(len[15:8]);
        stream_add(len[7:0]);
      end
      default: begin
        stream_add({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) stream_add(len[8*i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) stream_add(key[8*i +: 8]);
    for (int i = 0; i < n_pay; i++) stream_add(8'($urandom_range(0, 255)));
    frames_queued++;
  endtask

  always @(posedge clk) begin : byte_drv
    logic fire;
    fire = in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (fire) begin
        deframe_byte(in_ch.data_byte);
        bytes_accepted++;
      end
      if (fire || !in_ch.valid) begin
        if (in_gap != 0) begin
          in_ch.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (byte_stream.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data_byte <= byte_stream.pop_front();
          in_gap <= pick_gap(in_steady);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 49) == 0) in_steady <= ~in_steady;
    end
  end

  always @(posedge clk) begin : result_mon
    wfd_pkg::result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (deframed_q.size() == 0) begin
          report("result with none pending",
                 64'({out_ch.payload_byte, out_ch.has_byte, out_ch.frame_kind, out_ch.last}),
                 64'd0);
        end else begin
          want = deframed_q.pop_front();
          kind_hits[want.frame_kind]++;
          if (out_ch.payload_byte !== want.payload_byte)
            report("payload_byte", 64'(out_ch.payload_byte), 64'(want.payload_byte));
          if (out_ch.has_byte !== want.has_byte)
            report("has_byte", 64'(out_ch.has_byte), 64'(want.has_byte));
          if (out_ch.frame_kind !== want.frame_kind)
            report("frame_kind", 64'(out_ch.frame_kind), 64'(want.frame_kind));
          if (out_ch.last !== want.last)
            report("last", 64'(out_ch.last), 64'(want.last));
        end
      end
      if (out_stall != 0) begin
        out_ch.ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall <= pick_gap(out_steady);
      end
      if ($urandom_range(0, 49) == 0) out_steady <= ~out_steady;
    end
  end

  initial begin
    int unsigned start;
    int unsigned r;
    int unsigned form;
    logic [63:0] len;
    logic [7:0]  hdr;
    logic [3:0]  op;

    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    rx_phase = wfd_pkg::PH_HDR0;
    rx_kind = '0;
    rx_masked = 1'b0;
    rx_field_left = '0;
    rx_remaining = '0;
    rx_key = '0;
    rx_key_pos = '0;

    // directed frames: every decoded opcode plus reserved ones, fin both ways, empty frames on each header end
    add_frame({1'b1, 3'b000, wfd_pkg::OP_TEXT},   1'b0, LEN_SHORT, 64'd3,   32'h0, 3);
    add_frame({1'b0, 3'b000, wfd_pkg::OP_TEXT},   1'b1, LEN_SHORT, 64'd5,   32'hFFFFFFFF, 5);
    add_frame({1'b1, 3'b000, wfd_pkg::OP_CONT},   1'b1, LEN_SHORT, 64'd6,   32'h00000000, 6);
    add_frame({1'b0, 3'b000, wfd_pkg::OP_CONT},   1'b0, LEN_SHORT, 64'd0,   32'h0, 0);
    add_frame({1'b1, 3'b000, wfd_pkg::OP_BINARY}, 1'b1, LEN_SHORT, 64'd0,   32'hA5C3_5A3C, 0);
    add_frame({1'b0, 3'b000, wfd_pkg::OP_BINARY}, 1'b1, LEN_SHORT, 64'd125, $urandom, 125);
    add_frame({1'b1, 3'b000, wfd_pkg::OP_PING},   1'b1, LEN_SHORT, 64'd4,   $urandom, 4);
    add_frame({1'b1, 3'b000, wfd_pkg::OP_PONG},   1'b0, LEN_SHORT, 64'd1,   32'h0, 1);
    add_frame(8'h88,                              1'b0, LEN_SHORT, 64'd2,   32'h0, 2);
    add_frame(8'hF3,                              1'b1, LEN_SHORT, 64'd1,   $urandom, 1);
    add_frame(8'h7B,                              1'b0, LEN_SHORT, 64'd0,   32'h0, 0);
    add_frame(8'h8F,                              1'b0, LEN_SHORT, 64'd6,   32'h0, 6);
    add_frame({1'b1, 3'b111, wfd_pkg::OP_BINARY}, 1'b0, LEN_EXT16, 64'd0,   32'h0, 0);
    add_frame({1'b1, 3'b000, wfd_pkg::OP_TEXT},   1'b1, LEN_EXT16, 64'd300, $urandom, 300);
    add_frame({1'b1, 3'b000, wfd_pkg::OP_BINARY}, 1'b0, LEN_EXT16, 64'd126, 32'h0, 126);
    add_frame({1'b1, 3'b000, wfd_pkg::OP_PING},   1'b1, LEN_EXT64, 64'd0,   $urandom, 0);
    add_frame({1'b0, 3'b000, wfd_pkg::OP_BINARY}, 1'b0, LEN_EXT64, 64'd7,   32'h0, 7);

    start = byte_stream.size();
    while (byte_stream.size() - start < RANDOM_BYTES) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       op = wfd_pkg::OP_CONT;
        1, 2:    op = wfd_pkg::OP_TEXT;
        3, 4:    op = wfd_pkg::OP_BINARY;
        5:       op = wfd_pkg::OP_PING;
        6:       op = wfd_pkg::OP_PONG;
        default: op = 4'($urandom_range(0, 15));
      endcase
      hdr = {1'($urandom_range(0, 1)), 3'b000, op};
      if ($urandom_range(0, 7) == 0) hdr[6:4] = 3'($urandom_range(0, 7));
      r = $urandom_range(0, 19);
      if (r < 12) begin
        form = LEN_SHORT;
        len = 64'($urandom_range(0, 20));
      end else if (r < 14) begin
        form = LEN_SHORT;
        len = 64'($urandom_range(100, 125));
      end else if (r < 17) begin
        form = LEN_EXT16;
        len = 64'($urandom_range(0, 200));
      end else if (r < 19) begin
        form = LEN_EXT64;
        len = 64'($urandom_range(0, 30));
      end else begin
        form = LEN_EXT16;
        len = 64'($urandom_range(256, 520));
      end
      add_frame(hdr, 1'($urandom_range(0, 1)), form, len, $urandom, 32'(len));
    end

    // open-ended frame: full 64-bit length, stream stops inside the payload
    add_frame({1'b1, 3'b000, wfd_pkg::OP_BINARY}, 1'b1, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF,
              $urandom, 40);
    bytes_total = byte_stream.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted != bytes_total) @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("tb summary: %0d frames, %0d bytes sent, %0d results checked, %0d errors",
             frames_queued, bytes_accepted, results_seen, errors);
    $display("tb summary: text %0d, text part %0d, binary %0d, binary part %0d, %s",
             kind_hits[wfd_pkg::KIND_TEXT], kind_hits[wfd_pkg::KIND_TEXT_PART],
             kind_hits[wfd_pkg::KIND_BINARY], kind_hits[wfd_pkg::KIND_BINARY_PART],
             $sformatf("ping %0d, pong %0d, error %0d", kind_hits[wfd_pkg::KIND_PING],
                       kind_hits[wfd_pkg::KIND_PONG], kind_hits[wfd_pkg::KIND_ERROR]));
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
